/* rtl/midi_clock_beat_tracker_defines.svh */
// ----------------------------------------------------------------------------
// MIDI clock beat tracker assertion macros
// Shared assertion macros for the beat tracker RTL.
// ----------------------------------------------------------------------------
`ifndef MIDI_CLOCK_BEAT_TRACKER_DEFINES_SVH
`define MIDI_CLOCK_BEAT_TRACKER_DEFINES_SVH

`ifndef ASSERT_OFF
`define MCBT_ASSERT(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("beat tracker assertion failed");
`define MCBT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("beat tracker assertion failed");
`else
`define MCBT_ASSERT(lbl, clk, rst_n, expr)
`define MCBT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/mcbt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI clock beat tracker package
// Types, command codes and constants shared by the beat tracker modules.
// ----------------------------------------------------------------------------
package mcbt_pkg;

    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_MIDI = 2'd1;
    localparam logic [1:0] KIND_TAP  = 2'd2;

    localparam logic [7:0]  MIDI_CLOCK    = 8'd248;
    localparam logic [7:0]  MIDI_START    = 8'd250;
    localparam logic [15:0] MS_PER_MIN    = 16'd60000;
    localparam logic [31:0] TAP_HOLD_MS   = 32'd10;
    localparam logic [13:0] TICK_MAX      = 14'd16383;
    localparam logic [2:0]  TAP_COUNT_MAX = 3'd7;
    localparam logic [2:0]  TAP_COUNT_END = 3'd4;
    localparam logic [2:0]  BEAT_LAST     = 3'd7;
    localparam logic [8:0]  TEMPO_RESET   = 9'd60;

    localparam int CLOCKS_PER_BEAT_DEF = 24;
    localparam int QUEUE_DEPTH         = 4;

    typedef enum logic [2:0] {
        CMD_TICK,
        CMD_CLOCK,
        CMD_START,
        CMD_TAP,
        CMD_NONE
    } t_cmd;

    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] now_ms;
    } t_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LIMIT,
        S_BPM
    } t_state;

    typedef struct packed {
        logic        start;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [15:0] quot;
    } t_div_rsp;

endpackage

/* rtl/mcbt_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Beat tracker front end
// Accepts input beats, classifies them into commands and feeds the queue.
// ----------------------------------------------------------------------------
module mcbt_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_kind,
    input  logic [31:0]        i_now_ms,
    input  logic [7:0]         i_midi_byte,
    output logic               o_push,
    output mcbt_pkg::t_item    o_push_item,
    input  logic               i_full
);

    logic            r_valid;
    logic            n_valid;
    mcbt_pkg::t_item r_item;
    mcbt_pkg::t_item n_item;
    mcbt_pkg::t_cmd  w_cmd;
    logic            w_accept;

    assign o_in_stall  = r_valid && i_full;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_push      = r_valid && !i_full;
    assign o_push_item = r_item;

    always_comb begin
        case (i_kind)
            mcbt_pkg::KIND_TICK: w_cmd = mcbt_pkg::CMD_TICK;
            mcbt_pkg::KIND_TAP:  w_cmd = mcbt_pkg::CMD_TAP;
            mcbt_pkg::KIND_MIDI: begin
                if (i_midi_byte == mcbt_pkg::MIDI_CLOCK) begin
                    w_cmd = mcbt_pkg::CMD_CLOCK;
                end else if (i_midi_byte == mcbt_pkg::MIDI_START) begin
                    w_cmd = mcbt_pkg::CMD_START;
                end else begin
                    w_cmd = mcbt_pkg::CMD_NONE;
                end
            end
            default: w_cmd = mcbt_pkg::CMD_NONE;
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        n_item  = r_item;
        if (w_accept) begin
            n_valid       = 1'b1;
            n_item.cmd    = w_cmd;
            n_item.now_ms = i_now_ms;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_item <= n_item;
    end

endmodule

/* rtl/mcbt_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Beat tracker command queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module mcbt_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mcbt_pkg::t_item i_push_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output mcbt_pkg::t_item o_head
);

    localparam int DEPTH = mcbt_pkg::QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    mcbt_pkg::t_item r_slot [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   n_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [AW-1:0]   n_rd_ptr;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

/* rtl/mcbt_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Beat tracker divider
// Restoring divider for 60000 / divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mcbt_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mcbt_pkg::t_div_req i_req,
    output mcbt_pkg::t_div_rsp o_rsp
);

    localparam int QW = 16;
    localparam int SW = $clog2(QW);

    logic          r_busy;
    logic          n_busy;
    logic          r_done;
    logic          n_done;
    logic [SW-1:0] r_step;
    logic [SW-1:0] n_step;
    logic [QW-1:0] r_dvd;
    logic [QW-1:0] n_dvd;
    logic [QW-1:0] r_rem;
    logic [QW-1:0] n_rem;
    logic [31:0]   r_divisor;
    logic [31:0]   n_divisor;
    logic [QW:0]   w_shift;
    logic          w_fit;
    logic [31:0]   w_diff;

    assign w_shift = {r_rem, r_dvd[QW-1]};
    assign w_fit   = ({{(32 - QW - 1){1'b0}}, w_shift} >= r_divisor);
    assign w_diff  = {{(32 - QW - 1){1'b0}}, w_shift} - r_divisor;

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_dvd;

    always_comb begin
        n_busy    = r_busy;
        n_done    = 1'b0;
        n_step    = r_step;
        n_dvd     = r_dvd;
        n_rem     = r_rem;
        n_divisor = r_divisor;
        if (i_req.start) begin
            n_busy    = 1'b1;
            n_step    = SW'(QW - 1);
            n_dvd     = mcbt_pkg::MS_PER_MIN;
            n_rem     = '0;
            n_divisor = i_req.divisor;
        end else if (r_busy) begin
            n_dvd = {r_dvd[QW-2:0], w_fit};
            n_rem = w_fit ? w_diff[QW-1:0] : w_shift[QW-1:0];
            if (r_step == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_step = r_step - SW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_step    <= n_step;
        r_dvd     <= n_dvd;
        r_rem     <= n_rem;
        r_divisor <= n_divisor;
    end

endmodule

/* rtl/mcbt_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Beat tracker back end
// Executes queued commands, keeps the beat state and drives the result.
// ----------------------------------------------------------------------------
`include "midi_clock_beat_tracker_defines.svh"

module mcbt_back #(
    parameter int CLOCKS_PER_BEAT = mcbt_pkg::CLOCKS_PER_BEAT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic [8:0]         i_cfg_data,
    input  logic               i_empty,
    input  mcbt_pkg::t_item    i_head,
    output logic               o_pop,
    output mcbt_pkg::t_div_req o_div_req,
    input  mcbt_pkg::t_div_rsp i_div_rsp,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_beat_index,
    output logic               o_quarter_level,
    output logic [2:0]         o_midi_beat_index,
    output logic               o_midi_beat_event,
    output logic [31:0]        o_midi_period_ms,
    output logic [15:0]        o_midi_bpm,
    output logic               o_tap_level,
    output logic               o_tap_busy
);

    localparam int CCW = $clog2(CLOCKS_PER_BEAT + 1);

    mcbt_pkg::t_state r_state;
    mcbt_pkg::t_state n_state;

    logic [8:0]     r_tempo;
    logic           r_limit_stale;
    logic [13:0]    r_limit;
    logic [13:0]    r_tick_count;
    logic [13:0]    n_tick_count;
    logic [2:0]     r_local_beat;
    logic [2:0]     n_local_beat;
    logic [CCW-1:0] r_clock_count;
    logic [CCW-1:0] n_clock_count;
    logic [2:0]     r_midi_beat;
    logic [2:0]     n_midi_beat;
    logic [31:0]    r_last_boundary;
    logic [31:0]    n_last_boundary;
    logic [31:0]    r_period;
    logic [31:0]    n_period;
    logic [15:0]    r_bpm;
    logic           r_tap_active;
    logic           n_tap_active;
    logic [2:0]     r_tap_seen;
    logic [2:0]     n_tap_seen;
    logic [31:0]    r_tap_start;
    logic [31:0]    n_tap_start;
    logic [2:0]     r_tap_count;
    logic [2:0]     n_tap_count;
    logic           r_tap_pin;
    logic           n_tap_pin;

    logic           r_out_valid;
    logic [2:0]     r_out_beat;
    logic [2:0]     r_out_midi_beat;
    logic           r_out_event;
    logic [31:0]    r_out_period;
    logic [15:0]    r_out_bpm;
    logic           r_out_tap_pin;
    logic           r_out_tap_busy;

    logic           w_out_free;
    logic           w_boundary;
    logic           w_need_bpm;
    logic           w_midi_clock;
    logic           w_midi_start;
    logic [3:0]     w_midi_sum;
    logic [8:0]     w_tempo_nz;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_tempo_nz = (r_tempo == '0) ? 9'd1 : r_tempo;
    assign w_need_bpm = w_boundary && (n_period != '0);

    always_comb begin
        n_tick_count    = r_tick_count;
        n_local_beat    = r_local_beat;
        n_clock_count   = r_clock_count;
        n_midi_beat     = r_midi_beat;
        n_last_boundary = r_last_boundary;
        n_period        = r_period;
        n_tap_active    = r_tap_active;
        n_tap_seen      = r_tap_seen;
        n_tap_start     = r_tap_start;
        n_tap_count     = r_tap_count;
        n_tap_pin       = r_tap_pin;
        w_boundary      = 1'b0;
        w_midi_sum      = {1'b0, r_midi_beat} + 4'd2;

        if (i_head.cmd == mcbt_pkg::CMD_TICK && r_tick_count < mcbt_pkg::TICK_MAX) begin
            n_tick_count = r_tick_count + 14'd1;
        end
        if (i_head.cmd == mcbt_pkg::CMD_TAP) begin
            n_tap_active = 1'b1;
        end

        w_midi_clock = (i_head.cmd == mcbt_pkg::CMD_CLOCK) && !n_tap_active;
        w_midi_start = (i_head.cmd == mcbt_pkg::CMD_START) && !n_tap_active;

        if (w_midi_clock) begin
            if (r_clock_count >= CCW'(CLOCKS_PER_BEAT)) begin
                w_boundary      = 1'b1;
                n_clock_count   = CCW'(1);
                n_period        = i_head.now_ms - r_last_boundary;
                n_last_boundary = i_head.now_ms;
                n_midi_beat     = (w_midi_sum > 4'(mcbt_pkg::BEAT_LAST)) ? 3'd0
                                                                         : w_midi_sum[2:0];
            end else begin
                n_clock_count = r_clock_count + CCW'(1);
            end
        end else if (w_midi_start) begin
            n_local_beat = 3'd0;
            n_midi_beat  = 3'd0;
        end

        if (n_tick_count >= r_limit) begin
            n_tick_count = '0;
            n_local_beat = n_local_beat + 3'd1;
        end

        if (n_tap_active) begin
            if (n_local_beat != r_tap_seen) begin
                n_tap_seen  = n_local_beat;
                n_tap_start = i_head.now_ms;
                if (!n_local_beat[0]) begin
                    n_tap_pin = 1'b0;
                    if (r_tap_count < mcbt_pkg::TAP_COUNT_MAX) begin
                        n_tap_count = r_tap_count + 3'd1;
                    end
                end
            end else if (i_head.now_ms - r_tap_start > mcbt_pkg::TAP_HOLD_MS) begin
                n_tap_pin = 1'b1;
                if (r_tap_count > mcbt_pkg::TAP_COUNT_END) begin
                    n_tap_count  = '0;
                    n_tap_active = 1'b0;
                end
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            mcbt_pkg::S_IDLE: begin
                if (r_limit_stale) begin
                    n_state = mcbt_pkg::S_LIMIT;
                end else if (o_pop && w_need_bpm) begin
                    n_state = mcbt_pkg::S_BPM;
                end
            end
            mcbt_pkg::S_LIMIT: begin
                if (i_div_rsp.done) begin
                    n_state = mcbt_pkg::S_IDLE;
                end
            end
            mcbt_pkg::S_BPM: begin
                if (i_div_rsp.done) begin
                    n_state = mcbt_pkg::S_IDLE;
                end
            end
            default: n_state = mcbt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_pop             = 1'b0;
        o_div_req.start   = 1'b0;
        o_div_req.divisor = {23'd0, w_tempo_nz};
        case (r_state)
            mcbt_pkg::S_IDLE: begin
                if (r_limit_stale) begin
                    o_div_req.start = 1'b1;
                end else begin
                    o_pop             = !i_empty && w_out_free;
                    o_div_req.start   = o_pop && w_need_bpm;
                    o_div_req.divisor = n_period;
                end
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= mcbt_pkg::S_IDLE;
            r_tempo         <= mcbt_pkg::TEMPO_RESET;
            r_limit_stale   <= 1'b1;
            r_tick_count    <= '0;
            r_local_beat    <= '0;
            r_clock_count   <= '0;
            r_midi_beat     <= '0;
            r_last_boundary <= '0;
            r_period        <= '0;
            r_bpm           <= '0;
            r_tap_active    <= 1'b0;
            r_tap_seen      <= '0;
            r_tap_start     <= '0;
            r_tap_count     <= '0;
            r_tap_pin       <= 1'b1;
            r_out_valid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_tempo       <= i_cfg_data;
                r_limit_stale <= 1'b1;
            end else if (r_state == mcbt_pkg::S_LIMIT && i_div_rsp.done) begin
                r_limit_stale <= 1'b0;
            end
            if (o_pop) begin
                r_tick_count    <= n_tick_count;
                r_local_beat    <= n_local_beat;
                r_clock_count   <= n_clock_count;
                r_midi_beat     <= n_midi_beat;
                r_last_boundary <= n_last_boundary;
                r_period        <= n_period;
                r_tap_active    <= n_tap_active;
                r_tap_seen      <= n_tap_seen;
                r_tap_start     <= n_tap_start;
                r_tap_count     <= n_tap_count;
                r_tap_pin       <= n_tap_pin;
                if (w_boundary && !w_need_bpm) begin
                    r_bpm <= '0;
                end
                r_out_valid <= !w_need_bpm;
            end else if (r_state == mcbt_pkg::S_BPM && i_div_rsp.done) begin
                r_bpm       <= i_div_rsp.quot;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end

        if (r_state == mcbt_pkg::S_LIMIT && i_div_rsp.done) begin
            r_limit <= i_div_rsp.quot[15:2];
        end

        if (o_pop) begin
            r_out_beat      <= n_local_beat;
            r_out_midi_beat <= n_midi_beat;
            r_out_event     <= w_boundary;
            r_out_period    <= n_period;
            r_out_bpm       <= w_boundary ? 16'd0 : r_bpm;
            r_out_tap_pin   <= n_tap_pin;
            r_out_tap_busy  <= n_tap_active;
        end else if (r_state == mcbt_pkg::S_BPM && i_div_rsp.done) begin
            r_out_bpm <= i_div_rsp.quot;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_beat_index      = r_out_beat;
    assign o_quarter_level   = ~r_out_beat[0];
    assign o_midi_beat_index = r_out_midi_beat;
    assign o_midi_beat_event = r_out_event;
    assign o_midi_period_ms  = r_out_period;
    assign o_midi_bpm        = r_out_bpm;
    assign o_tap_level       = r_out_tap_pin;
    assign o_tap_busy        = r_out_tap_busy;

    `MCBT_ASSERT(a_clock_count_range, i_clk, i_rst_n, r_clock_count <= CCW'(CLOCKS_PER_BEAT))
    `MCBT_ASSERT_IMP(a_idle_tap_count, i_clk, i_rst_n, !r_tap_active, r_tap_count == 3'd0)
    `MCBT_ASSERT_IMP(a_no_result_in_bpm, i_clk, i_rst_n, r_state == mcbt_pkg::S_BPM, !r_out_valid)
    `MCBT_ASSERT_IMP(a_beat_hold, i_clk, i_rst_n, !$past(o_pop), $stable(r_local_beat))

endmodule

/* rtl/midi_clock_beat_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI clock beat tracker
// Tracks a local eighth-note position, a MIDI clock position and tempo, and
// drives a tap pulse burst.
// ----------------------------------------------------------------------------
// Each input beat yields exactly one result beat. A front stage classifies
// beats into a four-entry queue; the back end executes one queued command per
// cycle while its result register is empty or being taken, so a stalled result
// holds the back end while the front stage and the queue keep accepting beats
// until the queue is full. A MIDI clock that closes a beat with a nonzero
// period occupies the back end until the tempo is ready, because the tempo is
// computed by a shared divider that produces one quotient bit per cycle. After
// reset and after each tempo write the same divider derives the tick limit
// before the next command is executed. The configuration port is always ready.
module midi_clock_beat_tracker #(
    parameter int CLOCKS_PER_BEAT = mcbt_pkg::CLOCKS_PER_BEAT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_now_ms,
    input  logic [7:0]  i_midi_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_beat_index,
    output logic        o_quarter_level,
    output logic [2:0]  o_midi_beat_index,
    output logic        o_midi_beat_event,
    output logic [31:0] o_midi_period_ms,
    output logic [15:0] o_midi_bpm,
    output logic        o_tap_level,
    output logic        o_tap_busy,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [8:0]  i_cfg_data
);

    logic               w_push;
    mcbt_pkg::t_item    w_push_item;
    logic               w_full;
    logic               w_pop;
    logic               w_empty;
    mcbt_pkg::t_item    w_head;
    mcbt_pkg::t_div_req w_div_req;
    mcbt_pkg::t_div_rsp w_div_rsp;

    assign o_cfg_ready = 1'b1;

    mcbt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_kind      (i_kind),
        .i_now_ms    (i_now_ms),
        .i_midi_byte (i_midi_byte),
        .o_push      (w_push),
        .o_push_item (w_push_item),
        .i_full      (w_full)
    );

    mcbt_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_item (w_push_item),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_empty     (w_empty),
        .o_head      (w_head)
    );

    mcbt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    mcbt_back #(
        .CLOCKS_PER_BEAT (CLOCKS_PER_BEAT)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid && o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .i_empty           (w_empty),
        .i_head            (w_head),
        .o_pop             (w_pop),
        .o_div_req         (w_div_req),
        .i_div_rsp         (w_div_rsp),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_beat_index      (o_beat_index),
        .o_quarter_level   (o_quarter_level),
        .o_midi_beat_index (o_midi_beat_index),
        .o_midi_beat_event (o_midi_beat_event),
        .o_midi_period_ms  (o_midi_period_ms),
        .o_midi_bpm        (o_midi_bpm),
        .o_tap_level       (o_tap_level),
        .o_tap_busy        (o_tap_busy)
    );

endmodule
